// ===== sv/indexed_block_allocator_core_defines.svh =====
// ---------------------------------------------------------------------------
// indexed block allocator assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef INDEXED_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define INDEXED_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define IBA_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iba assertion failed");

// next-cycle implication
`define IBA_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iba assertion failed");

`endif

// ===== sv/iba_pkg.sv =====
// ---------------------------------------------------------------------------
// iba_pkg
// sizes, codes and types shared by the indexed block allocator
// ---------------------------------------------------------------------------
package iba_pkg;

	localparam int NUM_BLOCKS      = 128;
	localparam int MAX_FILE_BLOCKS = 16;
	localparam int FILE_ID_BITS    = 8;

	localparam int MAP_AW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int PEND_AW = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
	localparam int CNT_W   = $clog2(MAX_FILE_BLOCKS + 1);

	localparam int BLK_W  = 7;
	localparam int FILE_W = 8;
	localparam int BCNT_W = 5;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_INDEX_BUSY = 2'd1,
		STATUS_DATA_BUSY  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROC,
		S_COMMIT_IDX,
		S_COMMIT_DATA,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [BCNT_W-1:0] data_count;
		logic [BLK_W-1:0]  block_number;
		logic [FILE_W-1:0] file_number;
		logic              is_header;
	} item_t;

	// one access of the shared map port: lookup always, claim when set
	typedef struct packed {
		logic             claim;
		logic [BLK_W-1:0] blk;
	} map_req_t;

endpackage

// ===== sv/iba_map.sv =====
// ---------------------------------------------------------------------------
// iba_map
// block ownership map with one shared lookup and claim port
// ---------------------------------------------------------------------------
module iba_map (
	input  logic              clk,
	input  logic              arst_n,
	input  iba_pkg::map_req_t req,
	output logic              free
);
	import iba_pkg::*;

	// owner ids never feed a result, so only the taken bits are held
	logic [NUM_BLOCKS-1:0] taken_q;
	logic                  in_range;
	logic [MAP_AW-1:0]     idx;

	assign in_range = (32'(req.blk) < 32'(NUM_BLOCKS));
	assign idx      = MAP_AW'(req.blk);
	assign free     = in_range && !taken_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else if (req.claim && in_range) begin
			taken_q[idx] <= 1'b1;
		end
	end

endmodule

// ===== sv/iba_pend.sv =====
// ---------------------------------------------------------------------------
// iba_pend
// buffer of the data blocks of the open request, registered read
// ---------------------------------------------------------------------------
module iba_pend (
	input  logic                      clk,
	input  logic                      we,
	input  logic [iba_pkg::PEND_AW-1:0] waddr,
	input  logic [iba_pkg::BLK_W-1:0]   wdata,
	input  logic [iba_pkg::PEND_AW-1:0] raddr,
	output logic [iba_pkg::BLK_W-1:0]   rdata
);
	import iba_pkg::*;

	logic [BLK_W-1:0] mem [MAX_FILE_BLOCKS];
	logic [BLK_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/indexed_block_allocator_core.sv =====
// ---------------------------------------------------------------------------
// indexed_block_allocator_core
// checks requests against the block map and claims index and data blocks
// ---------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: is_header; tdata: file, block, count
//  m_*      out  m_tvalid/m_tready  tdata: status, owner_file
//
//  an item with no result is accepted, then checked once on the map port
//  a commit claims the index block, then each data block in turn
//  a result then loads the result register, waiting while an earlier result is held with m_tready low
//  the map port is the single shared unit; s_tready is high only when idle
//  arst_n clears the map and all control state at once, no sweep
`include "indexed_block_allocator_core_defines.svh"

module indexed_block_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [7:0] file_number, [14:8] block_number, [19:15] data_count
	input  logic [0:0]  s_tuser,  // [0] is_header
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [1:0] status, [9:2] owner_file
);
	import iba_pkg::*;

	state_t                  state_q, state_d;
	item_t                   item_q;
	logic [FILE_ID_BITS-1:0] file_q, file_d;
	logic [BLK_W-1:0]        index_q, index_d;
	logic [CNT_W-1:0]        rem_q, rem_d;
	logic [CNT_W-1:0]        recv_q, recv_d;
	logic [CNT_W-1:0]        k_q, k_d;
	logic                    allfree_q, allfree_d;
	status_t                 status_q, status_d;

	logic                    out_valid_q;
	logic [15:0]             out_data_q;
	logic                    load_out;

	map_req_t                map_req;
	logic                    map_free;
	logic                    pend_we;
	logic [PEND_AW-1:0]      pend_raddr;
	logic [BLK_W-1:0]        pend_rdata;
	logic [CNT_W-1:0]        cnt_sat;
	logic                    allfree_next;

	iba_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (map_req),
		.free   (map_free)
	);

	iba_pend u_pend (
		.clk   (clk),
		.we    (pend_we),
		.waddr (recv_q[PEND_AW-1:0]),
		.wdata (item_q.block_number),
		.raddr (pend_raddr),
		.rdata (pend_rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign cnt_sat = (32'(item_q.data_count) > 32'(MAX_FILE_BLOCKS)) ?
		CNT_W'(MAX_FILE_BLOCKS) : CNT_W'(item_q.data_count);
	assign allfree_next = allfree_q && map_free;

	always_comb begin
		state_d     = state_q;
		file_d      = file_q;
		index_d     = index_q;
		rem_d       = rem_q;
		recv_d      = recv_q;
		k_d         = k_q;
		allfree_d   = allfree_q;
		status_d    = status_q;
		load_out    = 1'b0;
		pend_we     = 1'b0;
		pend_raddr  = '0;
		map_req     = '{claim: 1'b0, blk: item_q.block_number};
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_PROC;
			end
			S_PROC: begin
				if (item_q.is_header) begin
					file_d    = FILE_ID_BITS'(item_q.file_number);
					index_d   = item_q.block_number;
					recv_d    = '0;
					allfree_d = 1'b1;
					rem_d     = '0;
					if (!map_free) begin
						status_d = STATUS_INDEX_BUSY;
						state_d  = S_EMIT;
					end else if (cnt_sat == '0) begin
						status_d = STATUS_OK;
						state_d  = S_COMMIT_IDX;
					end else begin
						rem_d   = cnt_sat;
						state_d = S_IDLE;
					end
				end else if (rem_q == '0) begin
					// stray data item
					state_d = S_IDLE;
				end else begin
					pend_we   = (32'(recv_q) < 32'(MAX_FILE_BLOCKS));
					recv_d    = recv_q + 1'b1;
					allfree_d = allfree_next;
					rem_d     = rem_q - 1'b1;
					if (rem_q == CNT_W'(1)) begin
						if (allfree_next) begin
							status_d = STATUS_OK;
							state_d  = S_COMMIT_IDX;
						end else begin
							status_d = STATUS_DATA_BUSY;
							state_d  = S_EMIT;
						end
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_COMMIT_IDX: begin
				map_req    = '{claim: 1'b1, blk: index_q};
				k_d        = '0;
				pend_raddr = '0;  // prefetch first data block
				state_d    = (recv_q == '0) ? S_EMIT : S_COMMIT_DATA;
			end
			S_COMMIT_DATA: begin
				map_req    = '{claim: 1'b1, blk: pend_rdata};
				pend_raddr = PEND_AW'(k_q + 1'b1);
				k_d        = k_q + 1'b1;
				if (CNT_W'(k_q + 1'b1) == recv_q) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			file_q    <= '0;
			index_q   <= '0;
			rem_q     <= '0;
			recv_q    <= '0;
			k_q       <= '0;
			allfree_q <= 1'b1;
			status_q  <= STATUS_OK;
		end else begin
			state_q   <= state_d;
			file_q    <= file_d;
			index_q   <= index_d;
			rem_q     <= rem_d;
			recv_q    <= recv_d;
			k_q       <= k_d;
			allfree_q <= allfree_d;
			status_q  <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q <= '{
				data_count:   s_tdata[19:15],
				block_number: s_tdata[14:8],
				file_number:  s_tdata[7:0],
				is_header:    s_tuser[0]
			};
		end
		if (load_out) begin
			out_data_q <= {6'd0, 8'(file_q), status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	`IBA_ASSERT_NXT(a_accept_to_proc, s_tvalid && s_tready, state_q == S_PROC)
	`IBA_ASSERT_IMP(a_recv_bound, 1'b1, 32'(recv_q) <= 32'(MAX_FILE_BLOCKS))
	`IBA_ASSERT_IMP(a_commit_in_range, state_q == S_COMMIT_DATA, k_q < recv_q)
	`IBA_ASSERT_IMP(a_status_code, m_tvalid, m_tdata[1:0] != 2'd3)

endmodule
